// ----- rtl/lsk_pkg.sv -----
// Shared definitions for the keyed-removal LIFO stack: sizes, request and
// status codes, controller states and the controller-to-datapath command.
// No dependencies.
package lsk_pkg;

   localparam int unsigned DEPTH   = 16;
   localparam int unsigned IDX_W   = $clog2(DEPTH);
   localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
   localparam int unsigned KEY_W   = 32;
   localparam int unsigned MOVES_W = 4;
   localparam int unsigned OCC_W   = 5;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic capture;  // latch the request and the per-cell compare results
      logic execute;  // apply the request to the cells and load the result
   } cmd_type;

endpackage

// ----- rtl/lsk_ctrl.sv -----
// Controller for the keyed-removal LIFO stack: request/result handshake
// sequencing and the result valid flag. Depends on lsk_pkg.
module lsk_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output lsk_pkg::cmd_type cmd
);

   lsk_pkg::state_type state_ff;
   lsk_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   // The result register can be reloaded when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsk_pkg::FSM_IDLE: begin
            if (req_tvalid) begin
               state_in = lsk_pkg::FSM_EXEC;
            end
         end
         lsk_pkg::FSM_EXEC: begin
            if (out_free) begin
               state_in = lsk_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = lsk_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         lsk_pkg::FSM_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         lsk_pkg::FSM_EXEC: begin
            cmd.execute = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsk_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/lsk_datapath.sv -----
// Datapath for the keyed-removal LIFO stack: the cell array with per-cell
// key compare, the fill count, the shift-down logic and the result register.
// Depends on lsk_pkg.
module lsk_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  lsk_pkg::cmd_type              cmd,
   input  logic [1:0]                    req_mode,
   input  logic [lsk_pkg::KEY_W-1:0]     req_key,
   output logic [1:0]                    rsp_status,
   output logic [lsk_pkg::KEY_W-1:0]     rsp_removed_key,
   output logic [lsk_pkg::MOVES_W-1:0]   rsp_moves,
   output logic [lsk_pkg::OCC_W-1:0]     rsp_occupancy
);

   logic [lsk_pkg::KEY_W-1:0]   cells_ff [lsk_pkg::DEPTH];
   logic [lsk_pkg::KEY_W-1:0]   cells_in [lsk_pkg::DEPTH];
   logic [lsk_pkg::CNT_W-1:0]   fill_ff;
   logic [lsk_pkg::CNT_W-1:0]   fill_in;
   lsk_pkg::mode_type           mode_ff;
   logic [lsk_pkg::KEY_W-1:0]   key_ff;
   logic [lsk_pkg::DEPTH-1:0]   hit_ff;
   lsk_pkg::status_type         status_ff;
   lsk_pkg::status_type         status_in;
   logic [lsk_pkg::KEY_W-1:0]   removed_ff;
   logic [lsk_pkg::KEY_W-1:0]   removed_in;
   logic [lsk_pkg::MOVES_W-1:0] moves_ff;
   logic [lsk_pkg::MOVES_W-1:0] moves_in;
   logic [lsk_pkg::OCC_W-1:0]   occ_ff;
   logic [lsk_pkg::OCC_W-1:0]   occ_in;
   logic                        found;
   logic [lsk_pkg::IDX_W-1:0]   pos;
   logic [lsk_pkg::CNT_W-1:0]   top;

   // Topmost matching cell among the occupied ones.
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = 0; i < lsk_pkg::DEPTH; i++) begin
         if (hit_ff[i] && (lsk_pkg::CNT_W'(i) < fill_ff)) begin
            found = 1'b1;
            pos   = lsk_pkg::IDX_W'(i);
         end
      end
   end

   assign top = fill_ff - lsk_pkg::CNT_W'(1);

   always_comb begin
      cells_in   = cells_ff;
      fill_in    = fill_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      moves_in   = moves_ff;
      occ_in     = occ_ff;
      if (cmd.execute) begin
         status_in  = lsk_pkg::STAT_OK;
         removed_in = '0;
         moves_in   = '0;
         unique case (mode_ff)
            lsk_pkg::MODE_PUSH: begin
               if (fill_ff == lsk_pkg::CNT_W'(lsk_pkg::DEPTH)) begin
                  status_in = lsk_pkg::STAT_FULL;
               end else begin
                  for (int i = 0; i < lsk_pkg::DEPTH; i++) begin
                     if (lsk_pkg::CNT_W'(i) == fill_ff) begin
                        cells_in[i] = key_ff;
                     end
                  end
                  fill_in = fill_ff + lsk_pkg::CNT_W'(1);
               end
            end
            lsk_pkg::MODE_POP: begin
               if (fill_ff == '0) begin
                  status_in = lsk_pkg::STAT_EMPTY;
               end else begin
                  removed_in = cells_ff[top[lsk_pkg::IDX_W-1:0]];
                  fill_in    = top;
               end
            end
            lsk_pkg::MODE_REMOVE: begin
               if (fill_ff == '0) begin
                  status_in = lsk_pkg::STAT_EMPTY;
               end else if (!found) begin
                  status_in = lsk_pkg::STAT_NOTFOUND;
               end else begin
                  // The matching cell holds the search key itself.
                  removed_in = key_ff;
                  moves_in   = lsk_pkg::MOVES_W'(top - lsk_pkg::CNT_W'(pos));
                  for (int i = 0; i < lsk_pkg::DEPTH - 1; i++) begin
                     if ((lsk_pkg::CNT_W'(i) >= lsk_pkg::CNT_W'(pos)) &&
                         (lsk_pkg::CNT_W'(i) < top)) begin
                        cells_in[i] = cells_ff[i + 1];
                     end
                  end
                  fill_in = top;
               end
            end
            lsk_pkg::MODE_NONE: begin
               status_in = lsk_pkg::STAT_OK;
            end
            default: begin
               status_in = lsk_pkg::STAT_OK;
            end
         endcase
         occ_in = lsk_pkg::OCC_W'(fill_in);
      end
   end

   // Request capture: every cell compares against the incoming key at once.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= lsk_pkg::mode_type'(req_mode);
         key_ff  <= req_key;
         for (int i = 0; i < lsk_pkg::DEPTH; i++) begin
            hit_ff[i] <= (cells_ff[i] == req_key);
         end
      end
   end

   always_ff @(posedge clock) begin
      cells_ff   <= cells_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      moves_ff   <= moves_in;
      occ_ff     <= occ_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_removed_key = removed_ff;
   assign rsp_moves       = moves_ff;
   assign rsp_occupancy   = occ_ff;

endmodule

// ----- rtl/lifo_stack_with_keyed_removal_unit.sv -----
// Keyed-removal LIFO stack, top level: handshake controller plus datapath.
// A request accepted in the idle state is loaded into the result register from the execute
// state, which waits while an earlier result beat still waits there.
// Each request passes a capture step that latches the request and the parallel key
// compare, then an execute step on the cell array; only then is a new request taken.
// Reset (synchronous, active high) empties the stack and drops any pending beat.
module lifo_stack_with_keyed_removal_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] removed_key, [35:32] moves,
                                    // [40:36] occupancy, [47:41] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   lsk_pkg::cmd_type                cmd;
   logic [1:0]                      status;
   logic [lsk_pkg::KEY_W-1:0]       removed_key;
   logic [lsk_pkg::MOVES_W-1:0]     moves;
   logic [lsk_pkg::OCC_W-1:0]       occupancy;

   // The controller accepts a request only when idle; the result register
   // is reloaded once the previous beat is gone or leaving, so a finished
   // result may wait on the output while the next request is taken in.
   lsk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Cells compare the key in parallel on capture; the execute step shifts
   // the entries above a removed key down by one, all together.
   lsk_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_tuser),
      .req_key         (req_tdata),
      .rsp_status      (status),
      .rsp_removed_key (removed_key),
      .rsp_moves       (moves),
      .rsp_occupancy   (occupancy)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = {7'd0, occupancy, moves, removed_key};

endmodule

// ----- test/lifo_stack_result_checker.sv -----
// Result checker for the keyed-removal LIFO stack: watches both stream channels, predicts
// each response beat from its own copy of the stack and compares the beats field by field.
// Depends on lsk_pkg for the sizes and the request and status codes.
`timescale 1ns / 1ps

module lifo_stack_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] key
   input  logic [1:0]  req_tuser,    // [1:0] mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,    // [31:0] removed_key, [35:32] moves, [40:36] occupancy
   input  logic [1:0]  rsp_tuser,    // [1:0] status
   output int          outstanding,
   output int          fail_count
);

   typedef struct packed {
      lsk_pkg::status_type         status;
      logic [lsk_pkg::KEY_W-1:0]   removed_key;
      logic [lsk_pkg::MOVES_W-1:0] moves;
      logic [lsk_pkg::OCC_W-1:0]   occupancy;
   } stack_result_type;

   logic [lsk_pkg::KEY_W-1:0] cells [lsk_pkg::DEPTH];
   int                        fill;
   int                        errors;
   stack_result_type          expected_results [$];

   assign fail_count = errors;

   // Applies one request to the shadow stack and returns the response it should produce.
   function automatic stack_result_type apply_request(input lsk_pkg::mode_type mode,
                                                      input logic [lsk_pkg::KEY_W-1:0] key);
      stack_result_type res;
      int               pos;
      bit               found;
      res = '{status: lsk_pkg::STAT_OK, removed_key: '0, moves: '0, occupancy: '0};
      pos = 0;
      found = 0;
      case (mode)
         lsk_pkg::MODE_PUSH: begin
            if (fill >= lsk_pkg::DEPTH) begin
               res.status = lsk_pkg::STAT_FULL;
            end else begin
               cells[fill] = key;
               fill++;
            end
         end
         lsk_pkg::MODE_POP: begin
            if (fill == 0) begin
               res.status = lsk_pkg::STAT_EMPTY;
            end else begin
               fill--;
               res.removed_key = cells[fill];
            end
         end
         lsk_pkg::MODE_REMOVE: begin
            if (fill == 0) begin
               res.status = lsk_pkg::STAT_EMPTY;
            end else begin
               // Search from the top down; the first hit is the topmost duplicate.
               for (int i = fill - 1; i >= 0; i--) begin
                  if (!found && cells[i] == key) begin
                     found = 1;
                     pos = i;
                  end
               end
               if (!found) begin
                  res.status = lsk_pkg::STAT_NOTFOUND;
               end else begin
                  res.removed_key = cells[pos];
                  res.moves = lsk_pkg::MOVES_W'(fill - 1 - pos);
                  for (int j = pos; j < fill - 1; j++) begin
                     cells[j] = cells[j + 1];
                  end
                  fill--;
               end
            end
         end
         default: ;
      endcase
      res.occupancy = lsk_pkg::OCC_W'(fill);
      return res;
   endfunction

   initial begin
      errors = 0;
      fill = 0;
   end

   always @(posedge clock) begin : monitor
      stack_result_type seen;
      stack_result_type want;
      if (reset) begin
         fill = 0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status      = lsk_pkg::status_type'(rsp_tuser);
            seen.removed_key = rsp_tdata[31:0];
            seen.moves       = rsp_tdata[35:32];
            seen.occupancy   = rsp_tdata[40:36];
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: response beat with no request waiting: status %0d key %h",
                           $realtime, seen.status, seen.removed_key);
               end
            end else begin
               want = expected_results.pop_front();
               if (seen.status != want.status || seen.removed_key != want.removed_key ||
                   seen.moves != want.moves || seen.occupancy != want.occupancy) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: mismatch: expected status %0d key %h moves %0d occ %0d",
                              $realtime, want.status, want.removed_key, want.moves,
                              want.occupancy);
                     $display("%0t:           got status %0d key %h moves %0d occ %0d",
                              $realtime, seen.status, seen.removed_key, seen.moves,
                              seen.occupancy);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_request(lsk_pkg::mode_type'(req_tuser),
                                                     req_tdata));
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

// ----- test/tb.sv -----
// Top of the testbench for the keyed-removal LIFO stack: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on lsk_pkg, the stack unit and
// lifo_stack_result_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb;

   // Cycles without any accepted beat on either channel before the run is abandoned.
   localparam int STALL_LIMIT   = 1000;
   localparam int RANDOM_ITEMS  = 1600;
   // The last stretch of the random part runs with no idling on either side.
   localparam int QUIET_ITEMS   = 200;
   // Every so often the sender holds off until all responses are back.
   localparam int DRAIN_SPACING = 250;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] key
   logic [1:0]  req_tuser;    // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // [31:0] removed_key, [35:32] moves, [40:36] occupancy
   logic [1:0]  rsp_tuser;    // [1:0] status

   int outstanding;
   int fail_count;
   bit quiet;
   int idle_cycles;

   lifo_stack_with_keyed_removal_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lifo_stack_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Sends one request beat. All inputs change at the falling edge; the beat is taken at the
   // first rising edge where the unit is ready. Valid stays high after acceptance until the
   // next call or drain, which always changes it at the following falling edge, before the
   // unit can sample it again.
   task automatic send_request(input lsk_pkg::mode_type mode, input logic [31:0] key);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = key;
      req_tuser  = mode;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drops valid and waits until every predicted response has been received. The checker
   // updates its count through a register, so it trails the channels it watches.
   task automatic drain_stack_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Keys mostly come from a small pool so that removals hit often and duplicates pile up;
   // the rest are full-width random values so that every key bit toggles.
   function automatic logic [31:0] pick_key();
      logic [31:0] key;
      case ($urandom_range(0, 9))
         0: key = 32'h0000_0000;
         1: key = 32'h0000_0001;
         2: key = 32'h0000_0002;
         3: key = 32'hFFFF_FFFF;
         4: key = 32'h8000_0000;
         5: key = 32'h7FFF_FFFF;
         6: key = 32'hFFFF_FFFE;
         default: key = $urandom;
      endcase
      return key;
   endfunction

   // Alternating growth and shrink phases drive the stack from empty to full and back, so
   // full pushes, empty pops and long shifts on removal all show up regularly.
   function automatic lsk_pkg::mode_type pick_mode(input int item);
      int  roll;
      bit  growing;
      roll = $urandom_range(0, 99);
      growing = ((item / 40) % 2) == 0;
      if (roll < (growing ? 60 : 25)) begin
         return lsk_pkg::MODE_PUSH;
      end else if (roll < (growing ? 75 : 55)) begin
         return lsk_pkg::MODE_POP;
      end else if (roll < 95) begin
         return lsk_pkg::MODE_REMOVE;
      end else begin
         return lsk_pkg::MODE_NONE;
      end
   endfunction

   // Response back-pressure: ready drops in random bursts, with stretches in between where it
   // stays high, and no new burst starts during the quiet tail of the run.
   initial begin : response_pacing
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            rsp_tready = 1'b0;
            stall_left = $urandom_range(0, 5);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Watchdog: any cycle with a beat on either channel restarts the count.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = lsk_pkg::MODE_PUSH;
      quiet      = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. On an empty stack: pop, remove and the unused mode.
      send_request(lsk_pkg::MODE_POP,    32'h0000_0000);
      send_request(lsk_pkg::MODE_REMOVE, 32'h0000_0000);
      send_request(lsk_pkg::MODE_NONE,   32'hFFFF_FFFF);
      // Extreme keys, with a duplicate of 7FFF_FFFF further up.
      send_request(lsk_pkg::MODE_PUSH,   32'h8000_0000);
      send_request(lsk_pkg::MODE_PUSH,   32'h7FFF_FFFF);
      send_request(lsk_pkg::MODE_PUSH,   32'h0000_0000);
      send_request(lsk_pkg::MODE_PUSH,   32'h7FFF_FFFF);
      send_request(lsk_pkg::MODE_PUSH,   32'hFFFF_FFFF);
      // The topmost duplicate goes first, with one entry shifted down.
      send_request(lsk_pkg::MODE_REMOVE, 32'h7FFF_FFFF);
      // Removing the bottom entry shifts everything above it.
      send_request(lsk_pkg::MODE_REMOVE, 32'h8000_0000);
      // A key that is not stored leaves the stack alone.
      send_request(lsk_pkg::MODE_REMOVE, 32'h0000_3039);
      send_request(lsk_pkg::MODE_NONE,   32'h0000_0000);
      send_request(lsk_pkg::MODE_POP,    32'h1234_5678);
      // Fill the stack, then push once more while it is full.
      for (int i = 0; i < 14; i++) begin
         send_request(lsk_pkg::MODE_PUSH, 32'h0000_0100 + i);
      end
      send_request(lsk_pkg::MODE_PUSH,   32'h5A5A_5A5A);
      // Removing the bottom of a full stack gives the longest shift; then take the top.
      send_request(lsk_pkg::MODE_REMOVE, 32'h7FFF_FFFF);
      send_request(lsk_pkg::MODE_REMOVE, 32'h0000_010D);
      drain_stack_results();

      // Random part.
      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         if (item == RANDOM_ITEMS - QUIET_ITEMS) begin
            quiet = 1'b1;
         end
         if (item > 0 && item % DRAIN_SPACING == 0) begin
            drain_stack_results();
         end
         send_request(pick_mode(item), pick_key());
      end

      // All requests are in: wait for the last responses, then let the clock run on so that a
      // stray extra beat would still be caught.
      drain_stack_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
